>>> rtl/subtitle_overlay_pixel_blend_macros.svh
// Assertion macros shared by the subtitle overlay blend RTL.
`ifndef SUBTITLE_OVERLAY_PIXEL_BLEND_MACROS_SVH
`define SUBTITLE_OVERLAY_PIXEL_BLEND_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SOPB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SOPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/sopb_pkg.sv
// Types, register indexes and the divide-by-255 helper for the overlay blend.
package sopb_pkg;

    localparam int CH_NUM = 3;  // blue, green, red
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic [7:0]  chan_t;
    typedef logic [15:0] prod_t;

    typedef enum logic [2:0] {
        REG_BLEND_MODE         = 3'd0,
        REG_COLOR_RED          = 3'd1,
        REG_COLOR_GREEN        = 3'd2,
        REG_COLOR_BLUE         = 3'd3,
        REG_COLOR_TRANSPARENCY = 3'd4
    } reg_idx_t;

    typedef enum logic {
        MODE_MASK   = 1'b0,
        MODE_PREMUL = 1'b1
    } blend_mode_t;

    localparam chan_t FULL_SCALE = 8'd255;

    // x / 255 for x <= 255*255: (x + (x >> 8) + 1) >> 8
    function automatic chan_t div255(input prod_t x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

>>> rtl/sopb_if.sv
// Pixel channel interfaces: frame/overlay request in, blended pixel out.
interface sopb_in_if;
    logic  valid;
    logic  ready;
    logic [7:0] frame_blue;
    logic [7:0] frame_green;
    logic [7:0] frame_red;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] coverage;

    modport source (
        output valid, frame_blue, frame_green, frame_red,
               src_red, src_green, src_blue, src_alpha, coverage,
        input  ready
    );
    modport sink (
        input  valid, frame_blue, frame_green, frame_red,
               src_red, src_green, src_blue, src_alpha, coverage,
        output ready
    );
endinterface

interface sopb_out_if;
    logic  valid;
    logic  ready;
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;

    modport source (
        output valid, out_blue, out_green, out_red,
        input  ready
    );
    modport sink (
        input  valid, out_blue, out_green, out_red,
        output ready
    );
endinterface

>>> rtl/subtitle_overlay_pixel_blend.sv
// Subtitle overlay pixel blend: four-stage pipeline, premultiplied or coverage-mask mode.
//
// Takes one pixel request per clock while the output is not stalled and returns one
// blended pixel per request, in order, through the stage 1, 2, 3 and output registers.
// Stage 1 forms the
// 8x8 products (coverage times inverse transparency, or frame times inverse alpha),
// stage 2 divides by 255 and finishes the premultiplied sum, stage 3 forms the mask
// mix k*colour + (255-k)*frame, stage 4 divides by 255 into the output register.
// Each stage advances whenever the stage after it is empty or moving, so bubbles are
// squeezed out and a stall on the output holds every request in place. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no request is
// in flight; index 0 blend_mode, 1..3 red/green/blue, 4 transparency; other indexes
// are ignored. In premultiplied mode the sum wraps to 8 bits.
`include "subtitle_overlay_pixel_blend_macros.svh"

module subtitle_overlay_pixel_blend (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    sopb_in_if.sink    pix_in,
    sopb_out_if.source pix_out
);
    import sopb_pkg::*;

    // configuration registers
    blend_mode_t mode_reg;
    chan_t       color_reg [CH_NUM];
    chan_t       transp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_MASK;
            transp_reg <= '0;
            for (int c = 0; c < CH_NUM; c++)
            begin
                color_reg[c] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_BLEND_MODE:         mode_reg <= blend_mode_t'(cfg_data[0]);
                REG_COLOR_RED:          color_reg[CH_RED] <= cfg_data;
                REG_COLOR_GREEN:        color_reg[CH_GREEN] <= cfg_data;
                REG_COLOR_BLUE:         color_reg[CH_BLUE] <= cfg_data;
                REG_COLOR_TRANSPARENCY: transp_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    assign en4 = !out_valid_reg || pix_out.ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pix_in.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= pix_in.valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
            if (en3) s3_valid_reg <= s2_valid_reg;
            if (en4) out_valid_reg <= s3_valid_reg;
        end
    end

    // stage 1: products
    chan_t in_frame [CH_NUM];
    chan_t in_src   [CH_NUM];
    chan_t alpha_comp, inv_transp;
    prod_t kprod_next;
    prod_t pprod_next [CH_NUM];

    assign in_frame[CH_BLUE]  = pix_in.frame_blue;
    assign in_frame[CH_GREEN] = pix_in.frame_green;
    assign in_frame[CH_RED]   = pix_in.frame_red;
    assign in_src[CH_BLUE]    = pix_in.src_blue;
    assign in_src[CH_GREEN]   = pix_in.src_green;
    assign in_src[CH_RED]     = pix_in.src_red;

    always_comb
    begin
        alpha_comp = FULL_SCALE - pix_in.src_alpha;
        inv_transp = FULL_SCALE - transp_reg;
        kprod_next = {8'b0, pix_in.coverage} * {8'b0, inv_transp};
        for (int c = 0; c < CH_NUM; c++)
        begin
            pprod_next[c] = {8'b0, in_frame[c]} * {8'b0, alpha_comp};
        end
    end

    blend_mode_t s1_mode_reg;
    prod_t       s1_kprod_reg;
    prod_t       s1_pprod_reg [CH_NUM];
    chan_t       s1_src_reg   [CH_NUM];
    chan_t       s1_frame_reg [CH_NUM];

    always_ff @(posedge clk)
    begin
        if (en1 && pix_in.valid)
        begin
            s1_mode_reg  <= mode_reg;
            s1_kprod_reg <= kprod_next;
            for (int c = 0; c < CH_NUM; c++)
            begin
                s1_pprod_reg[c] <= pprod_next[c];
                s1_src_reg[c]   <= in_src[c];
                s1_frame_reg[c] <= in_frame[c];
            end
        end
    end

    // stage 2: divide, finish premultiplied sum (wraps to 8 bits)
    blend_mode_t s2_mode_reg;
    chan_t       s2_k_reg;
    chan_t       s2_premul_reg [CH_NUM];
    chan_t       s2_frame_reg  [CH_NUM];

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_mode_reg <= s1_mode_reg;
            s2_k_reg    <= div255(s1_kprod_reg);
            for (int c = 0; c < CH_NUM; c++)
            begin
                s2_premul_reg[c] <= s1_src_reg[c] + div255(s1_pprod_reg[c]);
                s2_frame_reg[c]  <= s1_frame_reg[c];
            end
        end
    end

    // stage 3: mask mix; sum stays at or below 255*255
    chan_t s2_inv_k;
    prod_t msum_next [CH_NUM];

    always_comb
    begin
        s2_inv_k = FULL_SCALE - s2_k_reg;
        for (int c = 0; c < CH_NUM; c++)
        begin
            msum_next[c] = {8'b0, s2_k_reg} * {8'b0, color_reg[c]}
                         + {8'b0, s2_inv_k} * {8'b0, s2_frame_reg[c]};
        end
    end

    blend_mode_t s3_mode_reg;
    prod_t       s3_msum_reg   [CH_NUM];
    chan_t       s3_premul_reg [CH_NUM];

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_mode_reg <= s2_mode_reg;
            for (int c = 0; c < CH_NUM; c++)
            begin
                s3_msum_reg[c]   <= msum_next[c];
                s3_premul_reg[c] <= s2_premul_reg[c];
            end
        end
    end

    // stage 4: final divide and mode select into the output register
    chan_t out_reg [CH_NUM];

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            for (int c = 0; c < CH_NUM; c++)
            begin
                out_reg[c] <= (s3_mode_reg == MODE_PREMUL) ? s3_premul_reg[c]
                                                           : div255(s3_msum_reg[c]);
            end
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.out_blue  = out_reg[CH_BLUE];
    assign pix_out.out_green = out_reg[CH_GREEN];
    assign pix_out.out_red   = out_reg[CH_RED];

    `SOPB_ASSERT_NOW(a_full_when_blocked, !en1,
        s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg,
        "input blocked while pipeline has a bubble")
    `SOPB_ASSERT_NEXT(a_s1_to_s2, s1_valid_reg && en2, s2_valid_reg,
        "request lost between stage 1 and 2")
    `SOPB_ASSERT_NEXT(a_s3_to_out, s3_valid_reg && en4, out_valid_reg,
        "request lost between stage 3 and output")
    `SOPB_ASSERT_NEXT(a_hold_s3, s3_valid_reg && !en4, s3_valid_reg && $stable(s3_mode_reg),
        "stage 3 changed while stalled")

endmodule

>>> dv/sopb_pixel_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the overlay blend: predicts each blended pixel and compares it with the output.
module sopb_pixel_checker
    import sopb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    sopb_in_if         pix_in,
    sopb_out_if        pix_out,
    output int         fail_count,
    output int         pending,
    output int         checked_count
);

    typedef chan_t [CH_NUM-1:0] px_t;

    blend_mode_t mode_q;
    chan_t       color_q [CH_NUM];
    chan_t       transp_q;
    px_t         expected_px [$];
    string       chan_name [CH_NUM] = '{"out_blue", "out_green", "out_red"};

    function automatic chan_t premul_chan(input chan_t src, input chan_t frame,
                                          input chan_t alpha);
        prod_t scaled;
        scaled = (prod_t'(frame) * prod_t'(FULL_SCALE - alpha)) / prod_t'(FULL_SCALE);
        // sum wraps to 8 bits, no saturation
        return src + scaled[7:0];
    endfunction

    function automatic chan_t mask_chan(input chan_t k, input chan_t colour,
                                        input chan_t frame);
        prod_t mix;
        mix = prod_t'(k) * prod_t'(colour) + prod_t'(FULL_SCALE - k) * prod_t'(frame);
        mix = mix / prod_t'(FULL_SCALE);
        return mix[7:0];
    endfunction

    function automatic px_t blend_px(input px_t frame, input px_t src, input chan_t alpha,
                                     input chan_t cov);
        px_t   res;
        prod_t kw;
        chan_t k;
        kw = (prod_t'(cov) * prod_t'(FULL_SCALE - transp_q)) / prod_t'(FULL_SCALE);
        k  = kw[7:0];
        for (int c = 0; c < CH_NUM; c++)
            res[c] = (mode_q == MODE_PREMUL) ? premul_chan(src[c], frame[c], alpha)
                                             : mask_chan(k, color_q[c], frame[c]);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        px_t want;
        px_t got;
        px_t pred;
        if (!rst_n)
        begin
            mode_q   = MODE_MASK;
            transp_q = '0;
            color_q  = '{default: '0};
            expected_px.delete();
            pending  = 0;
        end
        else
        begin
            // retire first so a result never matches the request taken on the same edge
            if (pix_out.valid && pix_out.ready)
            begin
                got = {pix_out.out_red, pix_out.out_green, pix_out.out_blue};
                if (expected_px.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: pixel out with no request pending, expected none, actual %h",
                             $time, got);
                end
                else
                begin
                    want = expected_px.pop_front();
                    checked_count++;
                    for (int c = 0; c < CH_NUM; c++)
                        if (got[c] !== want[c])
                        begin
                            fail_count++;
                            $display("%0t: %s mismatch, expected %0d, actual %0d",
                                     $time, chan_name[c], want[c], got[c]);
                        end
                end
            end
            if (pix_in.valid && pix_in.ready)
            begin
                pred = blend_px(
                    {pix_in.frame_red, pix_in.frame_green, pix_in.frame_blue},
                    {pix_in.src_red, pix_in.src_green, pix_in.src_blue},
                    pix_in.src_alpha, pix_in.coverage);
                expected_px = {expected_px, pred};
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BLEND_MODE:         mode_q = blend_mode_t'(cfg_data[0]);
                    REG_COLOR_RED:          color_q[CH_RED] = cfg_data;
                    REG_COLOR_GREEN:        color_q[CH_GREEN] = cfg_data;
                    REG_COLOR_BLUE:         color_q[CH_BLUE] = cfg_data;
                    REG_COLOR_TRANSPARENCY: transp_q = cfg_data;
                    default:                ;
                endcase
            end
            pending = expected_px.size();
        end
    end

endmodule

>>> dv/tb_subtitle_overlay_pixel_blend.sv
`timescale 1ns / 1ps
// Testbench top for the overlay blend: register settings, pixel requests, stalls and verdict.
module tb_subtitle_overlay_pixel_blend;
    import sopb_pkg::*;

    localparam int NUM_PHASES   = 10;
    localparam int PHASE_PIXELS = 125;
    localparam int RESET_CYCLES = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PERCENT = 16;
    localparam int IDX_TOP      = (1 << $bits(reg_idx_t)) - 1;

    typedef struct packed {
        chan_t frame_blue;
        chan_t frame_green;
        chan_t frame_red;
        chan_t src_red;
        chan_t src_green;
        chan_t src_blue;
        chan_t src_alpha;
        chan_t coverage;
    } pix_req_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    blend_mode_t cur_mode = MODE_MASK;
    int          fail_count;
    int          pending;
    int          checked_count;
    int          cycle_count;
    int          mask_pixels;
    int          premul_pixels;
    int          reg_writes;

    sopb_in_if  pix_in ();
    sopb_out_if pix_out ();

    subtitle_overlay_pixel_blend dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    sopb_pixel_checker blend_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pix_in        (pix_in),
        .pix_out       (pix_out),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked_count (checked_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        pix_out.ready <= rst_n && (!sink_idle_en || ($urandom_range(99) >= IDLE_PERCENT));

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("subtitle_overlay_pixel_blend verification failed");
        $finish;
    end

    function automatic chan_t rand_chan();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return chan_t'($urandom_range(255));
    endfunction

    function automatic pix_req_t rand_pixel();
        pix_req_t px;
        px.frame_blue  = rand_chan();
        px.frame_green = rand_chan();
        px.frame_red   = rand_chan();
        px.src_alpha   = rand_chan();
        px.coverage    = rand_chan();
        // keep most overlay colors properly premultiplied, the rest free to wrap
        if ($urandom_range(3) != 0)
        begin
            px.src_red   = chan_t'($urandom_range(px.src_alpha));
            px.src_green = chan_t'($urandom_range(px.src_alpha));
            px.src_blue  = chan_t'($urandom_range(px.src_alpha));
        end
        else
        begin
            px.src_red   = rand_chan();
            px.src_green = rand_chan();
            px.src_blue  = rand_chan();
        end
        return px;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_BLEND_MODE)
            cur_mode = blend_mode_t'(data[0]);
        @(negedge clk);
        cfg_we <= 1'b0;
        reg_writes++;
    endtask

    // drop valid and hold until every blended pixel is back
    task automatic wait_idle();
        @(negedge clk);
        pix_in.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic send_pixel(input pix_req_t px);
        @(negedge clk);
        while (src_idle_en && $urandom_range(99) < IDLE_PERCENT)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.frame_blue  <= px.frame_blue;
        pix_in.frame_green <= px.frame_green;
        pix_in.frame_red   <= px.frame_red;
        pix_in.src_red     <= px.src_red;
        pix_in.src_green   <= px.src_green;
        pix_in.src_blue    <= px.src_blue;
        pix_in.src_alpha   <= px.src_alpha;
        pix_in.coverage    <= px.coverage;
        @(posedge clk);
        while (!pix_in.ready)
            @(posedge clk);
        if (cur_mode == MODE_PREMUL)
            premul_pixels++;
        else
            mask_pixels++;
    endtask

    initial
    begin
        pix_in.valid       = 1'b0;
        pix_in.frame_blue  = '0;
        pix_in.frame_green = '0;
        pix_in.frame_red   = '0;
        pix_in.src_red     = '0;
        pix_in.src_green   = '0;
        pix_in.src_blue    = '0;
        pix_in.src_alpha   = '0;
        pix_in.coverage    = '0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // mask mode at reset values: black, opaque color
        send_pixel(pix_req_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});

        wait_idle();
        write_reg(REG_COLOR_RED, 8'd255);
        write_reg(REG_COLOR_GREEN, 8'd0);
        write_reg(REG_COLOR_BLUE, 8'd128);
        write_reg(REG_COLOR_TRANSPARENCY, 8'd0);
        send_pixel(pix_req_t'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        // overlay source bytes are ignored in mask mode
        send_pixel(pix_req_t'{8'd77, 8'd200, 8'd13, 8'd255, 8'd255, 8'd255, 8'd255, 8'd128});

        wait_idle();
        write_reg(REG_COLOR_TRANSPARENCY, 8'd255);
        send_pixel(pix_req_t'{8'd31, 8'd144, 8'd250, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});
        wait_idle();
        write_reg(REG_COLOR_TRANSPARENCY, 8'd128);
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255});

        // writes past the last register must leave every setting alone
        wait_idle();
        for (int i = int'(REG_COLOR_TRANSPARENCY) + 1; i <= IDX_TOP; i++)
            write_reg(3'(i), 8'hFF);
        send_pixel(pix_req_t'{8'd10, 8'd20, 8'd30, 8'd90, 8'd90, 8'd90, 8'd90, 8'd200});

        wait_idle();
        write_reg(REG_BLEND_MODE, chan_t'(MODE_PREMUL));
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
        // source above alpha: sum wraps
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0});
        send_pixel(pix_req_t'{8'd200, 8'd100, 8'd1, 8'd100, 8'd64, 8'd128, 8'd128, 8'd255});
        send_pixel(pix_req_t'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255});

        // only bit zero of the mode write counts
        wait_idle();
        write_reg(REG_BLEND_MODE, 8'hFE | chan_t'(MODE_MASK));
        send_pixel(pix_req_t'{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255});

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            logic       mode_bit;
            logic [6:0] upper;
            chan_t      red;
            chan_t      green;
            chan_t      blue;
            chan_t      transp;
            wait_idle();
            src_idle_en  = (ph != 4);
            sink_idle_en = (ph != 4);
            upper = 7'($urandom);
            if (ph == 0)
            begin
                mode_bit = MODE_MASK;
                {red, green, blue, transp} = {8'd255, 8'd255, 8'd255, 8'd0};
            end
            else if (ph == 2)
            begin
                mode_bit = MODE_MASK;
                {red, green, blue, transp} = {8'd0, 8'd0, 8'd0, 8'd255};
            end
            else
            begin
                mode_bit = (ph == 1) ? MODE_PREMUL : 1'($urandom_range(1));
                red      = rand_chan();
                green    = rand_chan();
                blue     = rand_chan();
                transp   = rand_chan();
            end
            write_reg(REG_BLEND_MODE, {upper, mode_bit});
            write_reg(REG_COLOR_RED, red);
            write_reg(REG_COLOR_GREEN, green);
            write_reg(REG_COLOR_BLUE, blue);
            write_reg(REG_COLOR_TRANSPARENCY, transp);
            if ($urandom_range(2) == 0)
                write_reg(3'($urandom_range(IDX_TOP, int'(REG_COLOR_TRANSPARENCY) + 1)),
                          chan_t'($urandom));

            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                if (ph == 5 && n == PHASE_PIXELS / 2)
                    wait_idle();
                send_pixel(rand_pixel());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES)
            @(negedge clk);

        $display("Blended %0d mask-mode and %0d premultiplied pixels, %0d register writes,",
                 mask_pixels, premul_pixels, reg_writes);
        $display("%0d results compared; settings spanned both modes, extremes, unused indexes.",
                 checked_count);
        if (fail_count == 0 && pending == 0)
            $display("subtitle_overlay_pixel_blend verification clean");
        else
            $display("subtitle_overlay_pixel_blend verification failed");
        $finish;
    end

endmodule
